[rtl/nnd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nnd_pkg
// shared constants, register indexes and control types of the
// nearest-neighbor downscaler
// ----------------------------------------------------------------------------
package nnd_pkg;

	localparam int unsigned SIZE_W            = 13;
	localparam int unsigned IDX_W             = 2;
	localparam int unsigned CHAN_W            = 8;
	localparam int unsigned PIXEL_W           = 32;
	localparam int unsigned MAX_DIMENSION_DEF = 4096;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

	// which axis the shared divider works on
	localparam logic SEL_WIDTH  = 1'b0;
	localparam logic SEL_HEIGHT = 1'b1;

	typedef struct packed {
		logic run;        // pixel transfers allowed
		logic cfg_we;     // register write, restarts the frame
		logic div_start;  // load divider operands
		logic div_sel;    // axis of the running division
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} ctrl_status_t;

endpackage : nnd_pkg
`default_nettype wire

[rtl/nearest_neighbor_downscaler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler
// streaming nearest-neighbor image downscaler with ARGB output
// ----------------------------------------------------------------------------
// usage:
//   source pixels enter in raster order on the in_valid/in_ready channel,
//   one red/green/blue transfer per pixel. selected pixels leave on the
//   out_valid/out_ready channel as argb_pixel with alpha 0xFF; frame_last
//   marks the final output pixel of the frame.
//   four size registers (src width/height, dst width/height) are written
//   through cfg_valid/cfg_index/cfg_data; cfg_ready is always high. a write
//   restarts the frame counters and kicks off the step divisions: one shared
//   restoring divider runs for width then height, so in_ready stays low after
//   the last register write until both divisions are done. throughput: one
//   source pixel per cycle outside divisions and stalls, paced by the single
//   output register. a selected pixel appears in the cycle after its transfer.
//   when the receiver stalls with a result pending, in_ready drops until
//   that result is taken (it follows out_ready in the same cycle).
//   reset: all sizes read as 1, counters cleared, ready for pixels at once.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler #(
	parameter int unsigned MAX_DIMENSION = nnd_pkg::MAX_DIMENSION_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration write channel
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [nnd_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [nnd_pkg::SIZE_W-1:0]   cfg_data,
	// source pixel channel
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [nnd_pkg::CHAN_W-1:0]   red,
	input  wire  [nnd_pkg::CHAN_W-1:0]   green,
	input  wire  [nnd_pkg::CHAN_W-1:0]   blue,
	// output pixel channel
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [nnd_pkg::PIXEL_W-1:0]  argb_pixel,
	output logic                         frame_last
);
	import nnd_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer: division runs after writes, pixel gating
	nnd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.status    (status),
		.cmd       (cmd)
	);

	// counters, accumulators and output register
	nnd_datapath #(
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.argb_pixel (argb_pixel),
		.frame_last (frame_last)
	);

endmodule : nearest_neighbor_downscaler
`default_nettype wire

[rtl/nnd_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nnd_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nnd_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [nnd_pkg::SIZE_W-1:0]   dividend,
	input  wire  [nnd_pkg::SIZE_W-1:0]   divisor,
	output logic                         done,
	output logic [nnd_pkg::SIZE_W-1:0]   quotient,
	output logic [nnd_pkg::SIZE_W-1:0]   remainder
);
	import nnd_pkg::*;

	localparam int unsigned CNT_W = $clog2(SIZE_W + 1);

	logic [SIZE_W-1:0] dvd_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [SIZE_W-1:0] quo_q;
	logic [SIZE_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SIZE_W:0]   trial;
	logic              fits;

	// partial remainder stays below the divisor, so it fits in SIZE_W bits
	always_comb begin
		trial = {rem_q, dvd_q[SIZE_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(SIZE_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SIZE_W-2:0], 1'b0};
			quo_q <= {quo_q[SIZE_W-2:0], fits};
			rem_q <= fits ? SIZE_W'(trial - {1'b0, dvs_q}) : trial[SIZE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule : nnd_div
`default_nettype wire

[rtl/nnd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nnd_ctrl
// sequencer: runs the step divisions after a register write, then
// lets pixels through
// ----------------------------------------------------------------------------
module nnd_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_valid,
	input  wire  [nnd_pkg::IDX_W-1:0]   cfg_index,
	input  nnd_pkg::ctrl_status_t       status,
	output nnd_pkg::ctrl_cmd_t          cmd
);
	import nnd_pkg::*;

	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_LOAD_W = 3'd1;
	localparam logic [2:0] ST_DIV_W  = 3'd2;
	localparam logic [2:0] ST_LOAD_H = 3'd3;
	localparam logic [2:0] ST_DIV_H  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       reg_write;

	// every index of the two-bit field names a register
	assign reg_write = cfg_valid && ((cfg_index == REG_SRC_WIDTH) ||
		(cfg_index == REG_SRC_HEIGHT) || (cfg_index == REG_DST_WIDTH) ||
		(cfg_index == REG_DST_HEIGHT));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN:    state_d = ST_RUN;
			ST_LOAD_W: state_d = ST_DIV_W;
			ST_DIV_W:  if (status.div_done) state_d = ST_LOAD_H;
			ST_LOAD_H: state_d = ST_DIV_H;
			ST_DIV_H:  if (status.div_done) state_d = ST_RUN;
			default:   state_d = ST_RUN;
		endcase
		if (reg_write) begin
			state_d = ST_LOAD_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.run       = (state_q == ST_RUN) && !reg_write;
		cmd.cfg_we    = reg_write;
		cmd.div_start = (state_q == ST_LOAD_W) || (state_q == ST_LOAD_H);
		cmd.div_sel   = ((state_q == ST_LOAD_H) || (state_q == ST_DIV_H)) ?
			SEL_HEIGHT : SEL_WIDTH;
	end

endmodule : nnd_ctrl
`default_nettype wire

[rtl/nnd_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nnd_datapath
// size registers, raster counters, incremental target accumulators and
// the output register
// ----------------------------------------------------------------------------
module nnd_datapath #(
	parameter int unsigned MAX_DIMENSION = nnd_pkg::MAX_DIMENSION_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  nnd_pkg::ctrl_cmd_t           cmd,
	output nnd_pkg::ctrl_status_t        status,
	input  wire  [nnd_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [nnd_pkg::SIZE_W-1:0]   cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [nnd_pkg::CHAN_W-1:0]   red,
	input  wire  [nnd_pkg::CHAN_W-1:0]   green,
	input  wire  [nnd_pkg::CHAN_W-1:0]   blue,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [nnd_pkg::PIXEL_W-1:0]  argb_pixel,
	output logic                         frame_last
);
	import nnd_pkg::*;

	localparam int unsigned REG_TOP   = (1 << SIZE_W) - 1;
	localparam int unsigned CLAMP_TOP = (MAX_DIMENSION > REG_TOP) ? REG_TOP : MAX_DIMENSION;
	localparam logic [SIZE_W-1:0] MAX_SIZE = CLAMP_TOP[SIZE_W-1:0];
	localparam logic [SIZE_W-1:0] ONE      = SIZE_W'(1);

	logic [SIZE_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [SIZE_W-1:0] sw, sh, dw, dh;

	logic [SIZE_W-1:0] qw_q, rw_q, qh_q, rh_q;
	logic [SIZE_W-1:0] scol_q, srow_q, ocol_q, orow_q;
	logic [SIZE_W-1:0] tcol_q, trow_q, crem_q, rrem_q;

	logic              div_done;
	logic [SIZE_W-1:0] div_quo, div_rem;

	logic              out_valid_q;
	logic [PIXEL_W-1:0] argb_q;
	logic              last_q;

	logic              in_fire;
	logic              col_end, row_end, row_hit, hit, last_hit;
	logic [SIZE_W:0]   crem_sum, rrem_sum;
	logic              col_carry, row_carry;
	logic [SIZE_W-1:0] crem_next, rrem_next, tcol_next, trow_next;

	// effective sizes
	always_comb begin
		sw = (src_width_q == '0) ? ONE :
			((src_width_q > MAX_SIZE) ? MAX_SIZE : src_width_q);
		sh = (src_height_q == '0) ? ONE :
			((src_height_q > MAX_SIZE) ? MAX_SIZE : src_height_q);
		dw = (dst_width_q == '0) ? ONE : ((dst_width_q > sw) ? sw : dst_width_q);
		dh = (dst_height_q == '0) ? ONE : ((dst_height_q > sh) ? sh : dst_height_q);
	end

	// step sizes: quotient and remainder of source over output size
	nnd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  ((cmd.div_sel == SEL_HEIGHT) ? sh : sw),
		.divisor   ((cmd.div_sel == SEL_HEIGHT) ? dh : dw),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign status.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= ONE;
			src_height_q <= ONE;
			dst_width_q  <= ONE;
			dst_height_q <= ONE;
		end else if (cmd.cfg_we) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= ONE;
			rw_q <= '0;
			qh_q <= ONE;
			rh_q <= '0;
		end else if (div_done) begin
			if (cmd.div_sel == SEL_HEIGHT) begin
				qh_q <= div_quo;
				rh_q <= div_rem;
			end else begin
				qw_q <= div_quo;
				rw_q <= div_rem;
			end
		end
	end

	// per-pixel decisions
	always_comb begin
		in_ready = cmd.run && (!out_valid_q || out_ready);
		in_fire  = in_valid && in_ready;
		col_end  = (scol_q >= (sw - ONE));
		row_end  = (srow_q >= (sh - ONE));
		row_hit  = (srow_q == trow_q) && (orow_q < dh);
		hit      = row_hit && (scol_q == tcol_q) && (ocol_q < dw);
		last_hit = (orow_q == (dh - ONE)) && (ocol_q == (dw - ONE));

		crem_sum  = {1'b0, crem_q} + {1'b0, rw_q};
		col_carry = (crem_sum >= {1'b0, dw});
		crem_next = col_carry ? SIZE_W'(crem_sum - {1'b0, dw}) : crem_sum[SIZE_W-1:0];
		tcol_next = tcol_q + qw_q + SIZE_W'(col_carry);

		rrem_sum  = {1'b0, rrem_q} + {1'b0, rh_q};
		row_carry = (rrem_sum >= {1'b0, dh});
		rrem_next = row_carry ? SIZE_W'(rrem_sum - {1'b0, dh}) : rrem_sum[SIZE_W-1:0];
		trow_next = trow_q + qh_q + SIZE_W'(row_carry);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scol_q <= '0;
			srow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			tcol_q <= '0;
			trow_q <= '0;
			crem_q <= '0;
			rrem_q <= '0;
		end else if (cmd.cfg_we) begin
			scol_q <= '0;
			srow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			tcol_q <= '0;
			trow_q <= '0;
			crem_q <= '0;
			rrem_q <= '0;
		end else if (in_fire) begin
			if (col_end) begin
				scol_q <= '0;
				ocol_q <= '0;
				tcol_q <= '0;
				crem_q <= '0;
				if (row_end) begin
					srow_q <= '0;
					orow_q <= '0;
					trow_q <= '0;
					rrem_q <= '0;
				end else begin
					srow_q <= srow_q + ONE;
					if (row_hit) begin
						orow_q <= orow_q + ONE;
						trow_q <= trow_next;
						rrem_q <= rrem_next;
					end
				end
			end else begin
				scol_q <= scol_q + ONE;
				if (hit) begin
					ocol_q <= ocol_q + ONE;
					tcol_q <= tcol_next;
					crem_q <= crem_next;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && hit) begin
			argb_q <= {ALPHA_OPAQUE, red, green, blue};
			last_q <= last_hit;
		end
	end

	assign out_valid  = out_valid_q;
	assign argb_pixel = argb_q;
	assign frame_last = last_q;

endmodule : nnd_datapath
`default_nettype wire
